FILE: rtl/ptot_pkg.sv
// Shared types and constants for the pointer tag object table.
package ptot_pkg;

   localparam int ENTRY_COUNT_DEFAULT = 256;
   localparam int ID_W   = 16;
   localparam int ADDR_W = 48;
   localparam int PTR_W  = 64;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;

   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
   localparam logic [OP_W-1:0] OP_RESIZE = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_TAG = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [PTR_W-1:0]  tagged_pointer;
      logic [ADDR_W-1:0] base_address;
      logic [ADDR_W-1:0] block_length;
   } req_type;

   typedef struct packed {
      logic [PTR_W-1:0]  pointer_out;
      logic [ADDR_W-1:0] stored_length;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic commit;
      logic clear;
   } cmd_type;

endpackage

FILE: rtl/pointer_tag_object_table.sv
// rsp_valid is registered and rises after commit in EXEC; EXEC holds while a result waits.
// A new request is taken only after the last one commits; each entry table is read in the
//   accept cycle and written in the commit cycle on its single port.
// A finished result may wait in the output register while the next request is taken.
// Reset: synchronous; then a sweep clears the live marks of all ENTRY_COUNT entries,
//   with req_ready low until it ends.
module pointer_tag_object_table #(
   parameter int ENTRY_COUNT = ptot_pkg::ENTRY_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptot_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptot_pkg::rsp_type rsp_data
);
   import ptot_pkg::*;

   localparam int IDX_W = $clog2(ENTRY_COUNT);

   cmd_type          cmd;
   logic [IDX_W-1:0] clear_addr;

   ptot_ctrl #(
      .ENTRY_COUNT(ENTRY_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .clear_addr (clear_addr)
   );

   ptot_datapath #(
      .ENTRY_COUNT(ENTRY_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .clear_addr (clear_addr),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: rtl/ptot_ctrl.sv
// Sequencer: post-reset clearing sweep, request accept and commit handshake.
module ptot_ctrl #(
   parameter int ENTRY_COUNT = ptot_pkg::ENTRY_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ptot_pkg::cmd_type                 cmd,
   output logic [$clog2(ENTRY_COUNT)-1:0]    clear_addr
);
   import ptot_pkg::*;

   localparam int IDX_W = $clog2(ENTRY_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign clear_addr = clr_cnt_ff;

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear  = 1'b1;
            clr_cnt_in = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/ptot_datapath.sv
// Entry tables, free-list pointers, request latch and result register.
module ptot_datapath #(
   parameter int ENTRY_COUNT = ptot_pkg::ENTRY_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ptot_pkg::req_type                 req_data,
   input  ptot_pkg::cmd_type                 cmd,
   input  logic [$clog2(ENTRY_COUNT)-1:0]    clear_addr,
   output ptot_pkg::rsp_type                 rsp_data
);
   import ptot_pkg::*;

   localparam int IDX_W   = $clog2(ENTRY_COUNT);
   localparam int FRESH_W = $clog2(ENTRY_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRY_COUNT - 1);
   localparam logic [ID_W-1:0]  ID_COUNT  = ID_W'(ENTRY_COUNT);

   logic              live_mem [ENTRY_COUNT];
   logic [ADDR_W-1:0] base_mem [ENTRY_COUNT];
   logic [ADDR_W-1:0] len_mem  [ENTRY_COUNT];
   logic [ID_W-1:0]   next_mem [ENTRY_COUNT];

   req_type           req_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              live_rd_ff;
   logic [ADDR_W-1:0] base_rd_ff;
   logic [ADDR_W-1:0] len_rd_ff;
   logic [ID_W-1:0]   next_rd_ff;

   logic [ID_W-1:0]    head_ff, head_in;
   logic [ID_W-1:0]    tail_ff, tail_in;
   logic               empty_ff, empty_in;
   // entries at or above this index have never left the initial chain
   logic [FRESH_W-1:0] fresh_ff, fresh_in;

   logic [ID_W-1:0]   in_id, in_id_m1, head_m1;
   logic [IDX_W-1:0]  rd_idx;

   logic [ID_W-1:0]   tag_id, tag_m1, tail_m1, link;
   logic [IDX_W-1:0]  tag_idx, head_idx, tail_idx;
   logic              tag_ok, alloc_ok, on_fresh;

   logic              live_we, live_wd;
   logic [IDX_W-1:0]  live_wa;
   logic              data_we;
   logic [IDX_W-1:0]  data_wa;
   logic              next_we;

   // read address comes straight from the request (the head pointer for an alloc) so data is ready next cycle
   assign in_id    = req_data.tagged_pointer[PTR_W-1 -: ID_W];
   assign in_id_m1 = in_id - ID_W'(1);
   assign head_m1  = head_ff - ID_W'(1);
   assign rd_idx   = (req_data.op == OP_ALLOC) ? head_m1[IDX_W-1:0] : in_id_m1[IDX_W-1:0];

   assign tag_id   = req_ff.tagged_pointer[PTR_W-1 -: ID_W];
   assign tag_m1   = tag_id - ID_W'(1);
   assign tail_m1  = tail_ff - ID_W'(1);
   assign tag_idx  = tag_m1[IDX_W-1:0];
   assign head_idx = head_m1[IDX_W-1:0];
   assign tail_idx = tail_m1[IDX_W-1:0];

   assign tag_ok   = (tag_id != '0) && (tag_id <= ID_COUNT) && live_rd_ff;
   assign alloc_ok = !empty_ff;
   assign on_fresh = (FRESH_W'(head_idx) >= fresh_ff) && (head_idx != LAST_IDX);
   assign link     = on_fresh ? (head_ff + ID_W'(1)) : next_rd_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      empty_in = empty_ff;
      fresh_in = fresh_ff;
      live_we  = 1'b0;
      live_wd  = 1'b0;
      live_wa  = tag_idx;
      data_we  = 1'b0;
      data_wa  = tag_idx;
      next_we  = 1'b0;
      rsp_in   = '0;

      unique case (req_ff.op)
         OP_ALLOC: begin
            if (alloc_ok) begin
               live_we = 1'b1;
               live_wd = 1'b1;
               live_wa = head_idx;
               data_we = 1'b1;
               data_wa = head_idx;
               if (head_ff == tail_ff) begin
                  empty_in = 1'b1;
               end else begin
                  head_in = link;
               end
               if (FRESH_W'(head_idx) >= fresh_ff) begin
                  fresh_in = FRESH_W'(head_idx) + FRESH_W'(1);
               end
               rsp_in.pointer_out   = {head_ff, req_ff.base_address};
               rsp_in.stored_length = req_ff.block_length;
               rsp_in.status        = STAT_OK;
            end else begin
               rsp_in.status = STAT_FULL;
            end
         end
         OP_FREE: begin
            if (tag_ok) begin
               live_we = 1'b1;
               if (empty_ff) begin
                  head_in  = tag_id;
                  empty_in = 1'b0;
               end else begin
                  next_we = 1'b1;
               end
               tail_in = tag_id;
               rsp_in.pointer_out = {{ID_W{req_ff.tagged_pointer[ADDR_W-1]}},
                                     req_ff.tagged_pointer[ADDR_W-1:0]};
               rsp_in.status      = STAT_OK;
            end else begin
               rsp_in.status = STAT_BAD_TAG;
            end
         end
         OP_LOOKUP: begin
            if (tag_ok) begin
               rsp_in.pointer_out   = {{ID_W{1'b0}}, base_rd_ff};
               rsp_in.stored_length = len_rd_ff;
               rsp_in.status        = STAT_OK;
            end else begin
               rsp_in.status = STAT_BAD_TAG;
            end
         end
         OP_RESIZE: begin
            if (tag_ok) begin
               data_we              = 1'b1;
               rsp_in.pointer_out   = {{ID_W{1'b0}}, req_ff.base_address};
               rsp_in.stored_length = req_ff.block_length;
               rsp_in.status        = STAT_OK;
            end else begin
               rsp_in.status = STAT_BAD_TAG;
            end
         end
         default: begin
            rsp_in.status = STAT_BAD_TAG;
         end
      endcase
   end

   // live marks: cleared by the reset sweep, then written on commit
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         live_mem[clear_addr] <= 1'b0;
      end else if (cmd.commit && live_we) begin
         live_mem[live_wa] <= live_wd;
      end
      if (cmd.accept) begin
         live_rd_ff <= live_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && data_we) begin
         base_mem[data_wa] <= req_ff.base_address;
      end
      if (cmd.accept) begin
         base_rd_ff <= base_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && data_we) begin
         len_mem[data_wa] <= req_ff.block_length;
      end
      if (cmd.accept) begin
         len_rd_ff <= len_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && next_we) begin
         next_mem[tail_idx] <= tag_id;
      end
      if (cmd.accept) begin
         next_rd_ff <= next_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= ID_W'(1);
         tail_ff  <= ID_COUNT;
         empty_ff <= 1'b0;
         fresh_ff <= '0;
      end else if (cmd.commit) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         fresh_ff <= fresh_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
